>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, masked while reset is high
`define QPE_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, masked while reset is high
`define QPE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// next-cycle implication that also holds across reset
`define QPE_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> sv/qpe_pkg.sv
// ----------------------------------------------------------------------------
// qpe_pkg
// Character codes, run entry type and helpers for the QP encoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package qpe_pkg;

   localparam logic [7:0] CHAR_TAB   = 8'd9;
   localparam logic [7:0] CHAR_LF    = 8'd10;
   localparam logic [7:0] CHAR_CR    = 8'd13;
   localparam logic [7:0] CHAR_SPACE = 8'd32;
   localparam logic [7:0] CHAR_EQ    = 8'd61;
   localparam logic [7:0] PRINT_LO   = 8'd33;
   localparam logic [7:0] PRINT_HI   = 8'd126;

   localparam int         COL_W       = 7;
   localparam logic [COL_W-1:0] LIMIT_RESET = 7'd72;

   localparam int MAX_RUN   = 8;
   localparam int RUN_IDX_W = 3;
   localparam int RUN_CNT_W = 4;

   localparam int QUEUE_DEPTH_DEF = 4;

   // one input item worth of output characters
   typedef struct packed {
      logic [MAX_RUN-1:0][7:0] chars;
      logic [RUN_CNT_W-1:0]    count;
      logic                    last;
   } entry_type;

   function automatic logic [7:0] hex_digit(input logic [3:0] v);
      logic [7:0] r;
      if (v < 4'd10) begin
         r = 8'd48 + {4'd0, v};
      end else begin
         r = 8'd55 + {4'd0, v};
      end
      return r;
   endfunction

endpackage

`default_nettype wire

>>> sv/qpe_if.sv
// ----------------------------------------------------------------------------
// qpe_if
// Valid/ready channels of the QP encoder: request, response, register write.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface qpe_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_last;
   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface qpe_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       run_end;
   logic       message_end;
   modport source (output valid, output out_byte, output run_end, output message_end,
                   input ready);
   modport sink   (input valid, input out_byte, input run_end, input message_end,
                   output ready);
endinterface

interface qpe_csr_if;
   logic       valid;
   logic       ready;
   logic [6:0] line_limit;
   modport source (output valid, output line_limit, input ready);
   modport sink   (input valid, input line_limit, output ready);
endinterface

`default_nettype wire

>>> sv/quoted_printable_encoder.sv
// An accepted request word passes through the run queue and then the output register before its first response word.
// One response word per cycle while the response side is ready, set by the single output register;
//   a request word yields 1 to 8 of them.
// Requests are taken back to back while the run queue has room.
// Reset (synchronous, active high): line limit 72, column 0, queue empty.
// ----------------------------------------------------------------------------
// quoted_printable_encoder
// Quoted-printable encoder: raw message bytes in, encoded characters out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module quoted_printable_encoder #(
   parameter int QUEUE_DEPTH = qpe_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   qpe_req_if.sink   req_if,
   qpe_rsp_if.source rsp_if,
   qpe_csr_if.sink   csr_if
);
   import qpe_pkg::*;

   // front to queue
   logic      push_valid, push_ready;
   entry_type push_entry;

   // queue to back
   logic      head_valid, pop;
   entry_type head_entry;

   // Front: classify each word, update column and trailing-space state,
   // and build the full run of output characters combinationally.
   qpe_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .csr_if     (csr_if),
      .push_ready (push_ready),
      .push_valid (push_valid),
      .push_entry (push_entry)
   );

   // Queue: hold finished runs so the front keeps accepting while the
   // back drains a long run or the response side stalls.
   qpe_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .head_valid (head_valid),
      .pop        (pop),
      .head_entry (head_entry)
   );

   // Back: advance through the head run one character per cycle while the response side is ready, drop
   // the run from the queue on its final character.
   qpe_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp_if     (rsp_if)
   );

endmodule

`default_nettype wire

>>> sv/qpe_front.sv
// ----------------------------------------------------------------------------
// qpe_front
// Classify each input byte, track column state, build its output run.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qpe_front (
   input  wire logic          clock,
   input  wire logic          reset,
   qpe_req_if.sink            req_if,
   qpe_csr_if.sink            csr_if,
   input  wire logic          push_ready,
   output logic               push_valid,
   output qpe_pkg::entry_type push_entry
);
   import qpe_pkg::*;

   logic [COL_W-1:0] limit_ff;
   logic [COL_W-1:0] column_ff, column_in;
   logic             space_ff, space_in;

   logic [7:0]          b;
   logic                is_crlf, is_lit;
   logic [COL_W:0]      col;
   logic [RUN_CNT_W-1:0] n;
   logic [MAX_RUN-1:0][7:0] chars;
   logic                accept;

   assign b       = req_if.in_byte;
   assign is_crlf = (b == CHAR_CR) || (b == CHAR_LF);
   assign is_lit  = (b == CHAR_TAB) || (b == CHAR_SPACE) ||
                    ((b >= PRINT_LO) && (b <= PRINT_HI) && (b != CHAR_EQ));

   always_comb begin
      chars    = '0;
      n        = '0;
      col      = {1'b0, column_ff};
      space_in = space_ff;
      if (is_crlf) begin
         if (space_ff) begin
            chars[n[RUN_IDX_W-1:0]] = CHAR_EQ;
            n = n + 1'b1;
         end
         chars[n[RUN_IDX_W-1:0]] = b;
         n        = n + 1'b1;
         col      = '0;
         space_in = 1'b0;
      end else if (is_lit) begin
         chars[n[RUN_IDX_W-1:0]] = b;
         n        = n + 1'b1;
         col      = col + 1'b1;
         space_in = (b == CHAR_SPACE);
      end else begin
         chars[n[RUN_IDX_W-1:0]] = CHAR_EQ;
         n = n + 1'b1;
         chars[n[RUN_IDX_W-1:0]] = hex_digit(b[7:4]);
         n = n + 1'b1;
         chars[n[RUN_IDX_W-1:0]] = hex_digit(b[3:0]);
         n        = n + 1'b1;
         col      = col + (COL_W+1)'(3);
         space_in = 1'b0;
      end
      // soft line break
      if (col > {1'b0, limit_ff}) begin
         chars[n[RUN_IDX_W-1:0]] = CHAR_EQ;
         n = n + 1'b1;
         chars[n[RUN_IDX_W-1:0]] = CHAR_CR;
         n = n + 1'b1;
         chars[n[RUN_IDX_W-1:0]] = CHAR_LF;
         n        = n + 1'b1;
         col      = '0;
         space_in = 1'b0;
      end
      // message close
      if (req_if.in_last) begin
         chars[n[RUN_IDX_W-1:0]] = CHAR_CR;
         n = n + 1'b1;
         chars[n[RUN_IDX_W-1:0]] = CHAR_LF;
         n        = n + 1'b1;
         col      = '0;
         space_in = 1'b0;
      end
      column_in = col[COL_W-1:0];
   end

   assign req_if.ready = push_ready;
   assign csr_if.ready = 1'b1;
   assign accept       = req_if.valid && push_ready;
   assign push_valid   = req_if.valid;

   assign push_entry.chars = chars;
   assign push_entry.count = n;
   assign push_entry.last  = req_if.in_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff  <= LIMIT_RESET;
         column_ff <= '0;
         space_ff  <= 1'b0;
      end else begin
         if (csr_if.valid) begin
            limit_ff <= csr_if.line_limit;
         end
         if (accept) begin
            column_ff <= column_in;
            space_ff  <= space_in;
         end
      end
   end

endmodule

`default_nettype wire

>>> sv/qpe_queue.sv
// ----------------------------------------------------------------------------
// qpe_queue
// Short FIFO of output runs between the front and back parts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qpe_queue #(
   parameter int DEPTH = qpe_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push_valid,
   output logic               push_ready,
   input  wire qpe_pkg::entry_type push_entry,
   output logic               head_valid,
   input  wire logic          pop,
   output qpe_pkg::entry_type head_entry
);
   import qpe_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type        slots_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in;
   logic [PTR_W-1:0] rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign push_ready = (cnt_ff != CNT_W'(DEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head_entry = slots_ff[rd_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

`default_nettype wire

>>> sv/qpe_back.sv
// ----------------------------------------------------------------------------
// qpe_back
// Serialize the head run one character a cycle, while the response side is ready, into the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qpe_back (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          head_valid,
   input  wire qpe_pkg::entry_type head_entry,
   output logic               pop,
   qpe_rsp_if.source          rsp_if
);
   import qpe_pkg::*;

   logic [RUN_IDX_W-1:0] idx_ff, idx_in;
   logic                 valid_ff, valid_in;
   logic [7:0]           char_ff;
   logic                 run_end_ff, msg_end_ff;
   logic                 advance, run_done;

   assign advance  = head_valid && (!valid_ff || rsp_if.ready);
   assign run_done = ({1'b0, idx_ff} == (head_entry.count - 1'b1));
   assign pop      = advance && run_done;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (advance) begin
         idx_in   = run_done ? '0 : idx_ff + 1'b1;
         valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         char_ff    <= head_entry.chars[idx_ff];
         run_end_ff <= run_done;
         msg_end_ff <= run_done && head_entry.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_if.valid       = valid_ff;
   assign rsp_if.out_byte    = char_ff;
   assign rsp_if.run_end     = run_end_ff;
   assign rsp_if.message_end = msg_end_ff;

endmodule

`default_nettype wire

>>> sv/qpe_checker.sv
// ----------------------------------------------------------------------------
// qpe_checker
// Port-level checks on the QP encoder, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module qpe_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_byte,
   input wire logic       rsp_run_end,
   input wire logic       rsp_message_end
);
   import qpe_pkg::*;

   // hold a stalled response word
   `QPE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_byte) && $stable(rsp_run_end) && $stable(rsp_message_end))

   // message close is the LF that ends its run
   `QPE_ASSERT_IMPLY(a_msg_end_lf, clock, reset, rsp_valid && rsp_message_end, rsp_run_end && (rsp_byte == CHAR_LF))

   // reset empties the output and the run queue
   `QPE_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid && req_ready)

endmodule

bind quoted_printable_encoder qpe_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_if.ready),
   .rsp_valid       (rsp_if.valid),
   .rsp_ready       (rsp_if.ready),
   .rsp_byte        (rsp_if.out_byte),
   .rsp_run_end     (rsp_if.run_end),
   .rsp_message_end (rsp_if.message_end)
);

`default_nettype wire

>>> dv/qpe_scoreboard_pkg.sv
// ----------------------------------------------------------------------------
// qpe_scoreboard_pkg
// Expected-character store and encoding predictor for the QP encoder bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package qpe_scoreboard_pkg;

   typedef struct {
      logic [7:0] out_byte;
      logic       run_end;
      logic       message_end;
   } qp_char_type;

   class qp_scoreboard;
      logic [6:0]  line_limit;
      int unsigned column;
      bit          last_was_space;
      qp_char_type expected_chars[$];

      function new();
         line_limit     = qpe_pkg::LIMIT_RESET;
         column         = 0;
         last_was_space = 1'b0;
      endfunction

      function void set_limit(logic [6:0] v);
         line_limit = v;
      endfunction

      function int pending();
         return expected_chars.size();
      endfunction

      function logic [7:0] hex_char(logic [3:0] nib);
         if (nib < 4'd10) begin
            return 8'h30 + nib;
         end
         return 8'h41 + (nib - 4'd10);
      endfunction

      function void emit(logic [7:0] c);
         qp_char_type e;
         e.out_byte    = c;
         e.run_end     = 1'b0;
         e.message_end = 1'b0;
         expected_chars.push_back(e);
      endfunction

      // encode one accepted message byte into its expected output characters
      function void note_request(logic [7:0] b, logic last);
         int unsigned col;
         col = column;
         if (b == qpe_pkg::CHAR_CR || b == qpe_pkg::CHAR_LF) begin
            if (last_was_space) emit(qpe_pkg::CHAR_EQ);
            emit(b);
            col            = 0;
            last_was_space = 1'b0;
         end else if (b == qpe_pkg::CHAR_TAB || b == qpe_pkg::CHAR_SPACE ||
                      (b >= qpe_pkg::PRINT_LO && b <= qpe_pkg::PRINT_HI &&
                       b != qpe_pkg::CHAR_EQ)) begin
            emit(b);
            col            = col + 1;
            last_was_space = (b == qpe_pkg::CHAR_SPACE);
         end else begin
            emit(qpe_pkg::CHAR_EQ);
            emit(hex_char(b[7:4]));
            emit(hex_char(b[3:0]));
            col            = col + 3;
            last_was_space = 1'b0;
         end

         if (col > line_limit) begin
            emit(qpe_pkg::CHAR_EQ);
            emit(qpe_pkg::CHAR_CR);
            emit(qpe_pkg::CHAR_LF);
            col            = 0;
            last_was_space = 1'b0;
         end
         column = col & 32'h7F;

         if (last) begin
            emit(qpe_pkg::CHAR_CR);
            emit(qpe_pkg::CHAR_LF);
            expected_chars[expected_chars.size()-1].message_end = 1'b1;
            column         = 0;
            last_was_space = 1'b0;
         end
         expected_chars[expected_chars.size()-1].run_end = 1'b1;
      endfunction

      // compare one response word with the oldest expectation; empty string if it matches
      function string check_response(logic [7:0] ob, logic re, logic me);
         qp_char_type want;
         string       msg;
         if (expected_chars.size() == 0) begin
            return $sformatf("unexpected word out_byte=%02h run_end=%0b message_end=%0b",
                             ob, re, me);
         end
         want = expected_chars.pop_front();
         msg  = "";
         if (ob !== want.out_byte)
            msg = {msg, $sformatf(" out_byte got %02h want %02h", ob, want.out_byte)};
         if (re !== want.run_end)
            msg = {msg, $sformatf(" run_end got %0b want %0b", re, want.run_end)};
         if (me !== want.message_end)
            msg = {msg, $sformatf(" message_end got %0b want %0b", me, want.message_end)};
         if (msg != "") msg = {"word mismatch:", msg};
         return msg;
      endfunction
   endclass

endpackage

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives message bytes and line-limit writes into the QP encoder and checks
// every encoded character against a predictor, under varying back-pressure.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
   import qpe_scoreboard_pkg::*;

   localparam int STALL_LIMIT   = 2000;  // cycles with no handshake before giving up
   localparam int PHASE_WORDS   = 28;    // random words per line-limit setting
   localparam int NUM_PHASES    = 6;
   localparam int DRAIN_CYCLES  = 16;
   localparam int MAX_PRINTED   = 100;

   logic clock;
   logic reset;

   qpe_req_if req_ch ();
   qpe_rsp_if rsp_ch ();
   qpe_csr_if csr_ch ();

   quoted_printable_encoder u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch),
      .csr_if (csr_ch)
   );

   qp_scoreboard sb;
   int           error_count;
   int           send_idle_pct;
   int           recv_idle_pct;
   int           random_sent;
   int           stall_cycles;

   // 8 ns clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // mismatch reporting: one line each, print only the first batch
   // ------------------------------------------------------------------------
   task automatic report_mismatch(input string msg);
      if (error_count < MAX_PRINTED) $display("%0t: %s", $realtime, msg);
      error_count++;
   endtask

   // ------------------------------------------------------------------------
   // request side
   // ------------------------------------------------------------------------
   // present one word, called at a falling edge; returns at the falling edge
   // after the handshake with valid still high so back-to-back words stay up
   task automatic send_word(input logic [7:0] b, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.in_byte <= b;
      req_ch.in_last <= last;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sb.note_request(b, last);
      @(negedge clock);
   endtask

   // drop valid and hold until every expected character has come out
   task automatic drain();
      req_ch.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // write the line limit once the block has gone idle
   task automatic write_limit(input logic [6:0] v);
      drain();
      csr_ch.valid      <= 1'b1;
      csr_ch.line_limit <= v;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      sb.set_limit(v);
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   // bias toward text with spaces, line ends and a sprinkling of escapes
   function automatic logic [7:0] pick_byte();
      int r;
      r = $urandom_range(99);
      if (r < 40) return 8'($urandom_range(qpe_pkg::PRINT_HI, qpe_pkg::PRINT_LO));
      if (r < 52) return qpe_pkg::CHAR_SPACE;
      if (r < 57) return qpe_pkg::CHAR_CR;
      if (r < 62) return qpe_pkg::CHAR_LF;
      if (r < 67) return qpe_pkg::CHAR_EQ;
      if (r < 71) return qpe_pkg::CHAR_TAB;
      return 8'($urandom_range(255));
   endfunction

   // one message: mostly well-formed with a closing last flag, sometimes noise
   task automatic send_message();
      int len;
      len = $urandom_range(24, 1);
      if ($urandom_range(7) == 0) begin
         for (int i = 0; i < len; i++) begin
            send_word(8'($urandom_range(255)), ($urandom_range(5) == 0));
            random_sent++;
         end
      end else begin
         for (int i = 0; i < len; i++) begin
            send_word(pick_byte(), (i == len - 1));
            random_sent++;
         end
      end
   endtask

   // receiver idles more first, then sender, then neither
   task automatic set_idle_mode();
      if (random_sent < 56) begin
         send_idle_pct = 17;
         recv_idle_pct = 45;
      end else if (random_sent < 112) begin
         send_idle_pct = 45;
         recv_idle_pct = 17;
      end else begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end
   endtask

   // ------------------------------------------------------------------------
   // response side: random ready, changed at the falling edge
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // check every accepted response word at the rising edge
   always @(posedge clock) begin : rsp_monitor
      string msg;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         msg = sb.check_response(rsp_ch.out_byte, rsp_ch.run_end, rsp_ch.message_end);
         if (msg != "") report_mismatch(msg);
      end
   end

   // watchdog: too long without any handshake ends the run
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
            $display("tb_top: errors");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------------
   initial begin : main_seq
      logic [6:0] limits [NUM_PHASES];
      int         target;

      sb                = new();
      error_count       = 0;
      random_sent       = 0;
      stall_cycles      = 0;
      send_idle_pct     = 17;
      recv_idle_pct     = 45;
      reset             = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.in_byte    = 8'h00;
      req_ch.in_last    = 1'b0;
      rsp_ch.ready      = 1'b0;
      csr_ch.valid      = 1'b0;
      csr_ch.line_limit = qpe_pkg::LIMIT_RESET;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed part under the reset limit: literal edges, escapes, line ends
      send_word(8'h41, 1'b0);
      send_word(qpe_pkg::PRINT_LO, 1'b0);
      send_word(qpe_pkg::PRINT_HI, 1'b0);
      send_word(qpe_pkg::CHAR_TAB, 1'b0);
      send_word(qpe_pkg::CHAR_EQ, 1'b0);
      send_word(8'h00, 1'b0);
      send_word(8'hFF, 1'b0);
      send_word(8'h7F, 1'b0);
      send_word(8'h80, 1'b0);
      // space ahead of a line end gets an extra '='
      send_word(qpe_pkg::CHAR_SPACE, 1'b0);
      send_word(qpe_pkg::CHAR_CR, 1'b0);
      send_word(qpe_pkg::CHAR_SPACE, 1'b0);
      send_word(qpe_pkg::CHAR_LF, 1'b0);
      // bare line ends pass straight through
      send_word(qpe_pkg::CHAR_LF, 1'b0);
      send_word(qpe_pkg::CHAR_CR, 1'b0);
      // trailing space closes the message
      send_word(qpe_pkg::CHAR_SPACE, 1'b1);

      // tiny limit: column at the limit then a line end gives no soft break
      write_limit(7'd4);
      repeat (4) send_word(8'h41, 1'b0);
      send_word(qpe_pkg::CHAR_CR, 1'b0);
      // escape over the limit plus message close: longest run of characters
      send_word(8'h41, 1'b0);
      send_word(8'h41, 1'b0);
      send_word(8'h00, 1'b1);
      // space then a closing line end
      send_word(qpe_pkg::CHAR_SPACE, 1'b0);
      send_word(qpe_pkg::CHAR_CR, 1'b1);

      // random part over several limits, the extremes among them
      limits[0] = 7'd76;
      limits[1] = 7'd0;
      limits[2] = 7'd127;
      limits[3] = 7'd4;
      limits[4] = 7'($urandom_range(76, 4));
      limits[5] = 7'($urandom_range(127));
      for (int p = 0; p < NUM_PHASES; p++) begin
         write_limit(limits[p]);
         target = (p + 1) * PHASE_WORDS;
         while (random_sent < target) begin
            set_idle_mode();
            send_message();
         end
      end

      // drain, then let the pipeline settle
      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.pending() != 0)
         report_mismatch($sformatf("%0d expected words never arrived", sb.pending()));

      if (error_count == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule

>>> quoted_printable_encoder.f
+incdir+sv
sv/qpe_pkg.sv
sv/qpe_if.sv
sv/qpe_front.sv
sv/qpe_queue.sv
sv/qpe_back.sv
sv/quoted_printable_encoder.sv
sv/qpe_checker.sv
dv/qpe_scoreboard_pkg.sv
dv/tb_top.sv
